// ===== rtl/mtcqf_pkg.sv =====
// Package for the MIDI time code quarter-frame timekeeper.
// Holds the command format, nibble codes, limits and small lookup functions.
// No dependencies; imported by the front, queue, back and top-level modules.
package mtcqf_pkg;

  // Input mode codes as they arrive on the stream
  localparam logic [1:0] MODE_MERGE   = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_EMIT    = 2'd2;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // Stream widths
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;

  // Quarter-frame nibble types
  localparam logic [2:0] NIB_FRAME_LO = 3'd0;
  localparam logic [2:0] NIB_FRAME_HI = 3'd1;
  localparam logic [2:0] NIB_SEC_LO   = 3'd2;
  localparam logic [2:0] NIB_SEC_HI   = 3'd3;
  localparam logic [2:0] NIB_MIN_LO   = 3'd4;
  localparam logic [2:0] NIB_MIN_HI   = 3'd5;
  localparam logic [2:0] NIB_HOUR_LO  = 3'd6;
  localparam logic [2:0] NIB_HOUR_HI  = 3'd7;

  // Index of the final quarter-frame beat
  localparam logic [2:0] BEAT_LAST = 3'd7;

  // Clock field limits
  localparam logic [4:0] FRAME_MAX = 5'd29;
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;

  // Classified operation
  typedef enum logic [1:0] {
    OP_MERGE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_EMIT    = 2'd2,
    OP_INVALID = 2'd3
  } op_t;

  // Command carried from front to back
  typedef struct packed {
    op_t        op;
    logic       bad_byte;   // byte had bit 7 set
    logic [6:0] data;       // nibble type and value
    logic       backwards;  // emit order
  } cmd_t;

  // Back-end sequencing states
  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  // Bits that each nibble type defines
  function automatic logic [3:0] nibble_mask(input logic [2:0] nib);
    logic [3:0] m;
    case (nib)
      NIB_FRAME_LO: m = 4'hF;
      NIB_FRAME_HI: m = 4'h1;
      NIB_SEC_LO:   m = 4'hF;
      NIB_SEC_HI:   m = 4'h3;
      NIB_MIN_LO:   m = 4'hF;
      NIB_MIN_HI:   m = 4'h3;
      NIB_HOUR_LO:  m = 4'hF;
      default:      m = 4'h7;
    endcase
    return m;
  endfunction

  // Frames per second for each rate code (30 drop counts like 30)
  function automatic logic [5:0] rate_frames(input logic [1:0] rate);
    logic [5:0] f;
    case (rate)
      2'd0:    f = 6'd24;
      2'd1:    f = 6'd25;
      default: f = 6'd30;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/mtcqf_front.sv =====
// Front end: classifies an incoming stream item into a command.
// Depends on mtcqf_pkg (cmd_t, op_t, mode codes).
module mtcqf_front (
  input  logic [1:0]           mode,
  input  logic [7:0]           data_byte,
  input  logic                 backwards,
  output mtcqf_pkg::cmd_t      cmd
);
  import mtcqf_pkg::*;

  // Decode mode and pre-flag bytes with bit 7 set
  always_comb begin
    case (mode)
      MODE_MERGE:   cmd.op = OP_MERGE;
      MODE_ADVANCE: cmd.op = OP_ADVANCE;
      MODE_EMIT:    cmd.op = OP_EMIT;
      default:      cmd.op = OP_INVALID;
    endcase
    cmd.bad_byte  = data_byte[7];
    cmd.data      = data_byte[6:0];
    cmd.backwards = backwards;
  end

endmodule

// ===== rtl/mtcqf_queue.sv =====
// Small command queue between front and back ends.
// Depends on mtcqf_pkg (cmd_t).
module mtcqf_queue #(
  parameter int DEPTH = mtcqf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mtcqf_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output mtcqf_pkg::cmd_t rd_data,
  output logic            empty
);
  import mtcqf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mtcqf_back.sv =====
// Back end: holds the time code clock, executes commands and drives the
// output register. Depends on mtcqf_pkg (cmd_t, codes, limits, lookups).
module mtcqf_back (
  input  logic                            clk,
  input  logic                            rst,
  input  mtcqf_pkg::cmd_t                 cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mtcqf_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  output logic [0:0]                      m_tuser
);
  import mtcqf_pkg::*;

  // Clock state; it always matches the result held in the output register
  logic [4:0] frame,   frame_next;
  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [4:0] hours,   hours_next;
  logic [1:0] rate,    rate_next;

  // Emit sequencing
  bk_state_t  state, state_next;
  logic [2:0] beat_idx, beat_idx_next;
  logic       emit_back, emit_back_next;

  // Output register
  logic       out_valid;
  logic       out_status, out_status_next;
  logic [6:0] out_byte,   out_byte_next;
  logic       out_last,   out_last_next;

  logic       load;
  logic       step;

  // Merge datapath
  logic [2:0] nib;
  logic [3:0] nib_val;
  logic [4:0] m_frame;
  logic [5:0] m_seconds;
  logic [5:0] m_minutes;
  logic [4:0] m_hours;
  logic [1:0] m_rate;
  logic       m_reject;

  // Advance datapath
  logic [5:0] frame_inc;
  logic [4:0] a_frame;
  logic [5:0] a_seconds;
  logic [5:0] a_minutes;
  logic [4:0] a_hours;

  // Emit beat
  logic [2:0] beat_k;
  logic       beat_back;
  logic [2:0] beat_type;
  logic [3:0] beat_val;

  function automatic logic [3:0] nibble_value(
    input logic [2:0] t, input logic [4:0] f, input logic [5:0] s,
    input logic [5:0] mn, input logic [4:0] h, input logic [1:0] r);
    logic [3:0] v;
    case (t)
      NIB_FRAME_LO: v = f[3:0];
      NIB_FRAME_HI: v = {3'b000, f[4]};
      NIB_SEC_LO:   v = s[3:0];
      NIB_SEC_HI:   v = {2'b00, s[5:4]};
      NIB_MIN_LO:   v = mn[3:0];
      NIB_MIN_HI:   v = {2'b00, mn[5:4]};
      NIB_HOUR_LO:  v = h[3:0];
      default:      v = {1'b0, r, h[4]};
    endcase
    return v;
  endfunction

  // Handshake between output register and command queue
  assign load    = !out_valid || m_tready;
  assign cmd_pop = load && (state == BK_EXEC) && cmd_valid;
  assign step    = load && ((state == BK_EMIT) || cmd_valid);

  // Quarter-frame merge
  always_comb begin
    nib       = cmd.data[6:4];
    nib_val   = cmd.data[3:0] & nibble_mask(nib);
    m_frame   = frame;
    m_seconds = seconds;
    m_minutes = minutes;
    m_hours   = hours;
    m_rate    = rate;
    m_reject  = cmd.bad_byte;
    case (nib)
      NIB_FRAME_LO: m_frame   = {frame[4], nib_val};
      NIB_FRAME_HI: m_frame   = {nib_val[0], frame[3:0]};
      NIB_SEC_LO:   m_seconds = {seconds[5:4], nib_val};
      NIB_SEC_HI:   m_seconds = {nib_val[1:0], seconds[3:0]};
      NIB_MIN_LO:   m_minutes = {minutes[5:4], nib_val};
      NIB_MIN_HI:   m_minutes = {nib_val[1:0], minutes[3:0]};
      NIB_HOUR_LO:  m_hours   = {hours[4], nib_val};
      default: begin
        m_hours = {nib_val[0], hours[3:0]};
        m_rate  = nib_val[2:1];
        if ({1'b0, frame} >= rate_frames(nib_val[2:1])) begin
          m_frame = '0;
        end
      end
    endcase
    if (m_frame > FRAME_MAX || m_seconds > SEC_MAX || m_minutes > MIN_MAX
        || m_hours > HOUR_MAX) begin
      m_reject = 1'b1;
    end
  end

  // One-frame advance with carries, hours wrap at 24
  always_comb begin
    frame_inc = {1'b0, frame} + 6'd1;
    a_frame   = frame;
    a_seconds = seconds;
    a_minutes = minutes;
    a_hours   = hours;
    if (frame_inc < rate_frames(rate)) begin
      a_frame = frame_inc[4:0];
    end else begin
      a_frame = '0;
      if (seconds < SEC_MAX) begin
        a_seconds = seconds + 6'd1;
      end else begin
        a_seconds = '0;
        if (minutes < MIN_MAX) begin
          a_minutes = minutes + 6'd1;
        end else begin
          a_minutes = '0;
          a_hours   = (hours < HOUR_MAX) ? hours + 5'd1 : '0;
        end
      end
    end
  end

  // Emit beat selection: first beat comes straight from the command
  always_comb begin
    beat_k    = (state == BK_EMIT) ? beat_idx : 3'd0;
    beat_back = (state == BK_EMIT) ? emit_back : cmd.backwards;
    beat_type = beat_back ? ~beat_k : beat_k;
    beat_val  = nibble_value(beat_type, frame, seconds, minutes, hours, rate);
  end

  // Next-state logic for the emit sequencer
  always_comb begin
    state_next = state;
    case (state)
      BK_EXEC: begin
        if (cmd_pop && cmd.op == OP_EMIT) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load && beat_idx == BEAT_LAST) begin
          state_next = BK_EXEC;
        end
      end
      default: state_next = BK_EXEC;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    frame_next      = frame;
    seconds_next    = seconds;
    minutes_next    = minutes;
    hours_next      = hours;
    rate_next       = rate;
    beat_idx_next   = beat_idx;
    emit_back_next  = emit_back;
    out_status_next = 1'b0;
    out_byte_next   = '0;
    out_last_next   = 1'b1;
    if (state == BK_EMIT || cmd.op == OP_EMIT) begin
      out_byte_next  = {beat_type, beat_val};
      out_last_next  = (beat_k == BEAT_LAST);
      beat_idx_next  = beat_k + 3'd1;
      emit_back_next = beat_back;
    end else begin
      case (cmd.op)
        OP_MERGE: begin
          out_status_next = m_reject;
          if (!m_reject) begin
            frame_next   = m_frame;
            seconds_next = m_seconds;
            minutes_next = m_minutes;
            hours_next   = m_hours;
            rate_next    = m_rate;
          end
        end
        OP_ADVANCE: begin
          frame_next   = a_frame;
          seconds_next = a_seconds;
          minutes_next = a_minutes;
          hours_next   = a_hours;
        end
        default: out_status_next = 1'b1;
      endcase
    end
  end

  // Clock state, sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      frame     <= '0;
      seconds   <= '0;
      minutes   <= '0;
      hours     <= '0;
      rate      <= '0;
      state     <= BK_EXEC;
      beat_idx  <= '0;
      emit_back <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        frame     <= frame_next;
        seconds   <= seconds_next;
        minutes   <= minutes_next;
        hours     <= hours_next;
        rate      <= rate_next;
        beat_idx  <= beat_idx_next;
        emit_back <= emit_back_next;
      end
      state <= state_next;
      if (load) begin
        out_valid <= step;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_status <= out_status_next;
      out_byte   <= out_byte_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;
  assign m_tdata  = {1'b0, out_byte, rate, hours, minutes, seconds, frame};

endmodule

// ===== rtl/mtc_quarter_frame_timekeeper.sv =====
// MIDI time code quarter-frame timekeeper, top level.
// Depends on mtcqf_pkg, mtcqf_front, mtcqf_queue and mtcqf_back.
//
// Input stream (s_*): one command per transfer. s_tuser carries the mode
// (0 merge a quarter-frame byte, 1 advance one frame, 2 emit the eight
// quarter-frame bytes, 3 rejected). s_tdata carries the received byte and
// the emit direction.
// Output stream (m_*): one result per merge, advance or unused mode; eight
// results for an emit, m_tlast high on the final one. m_tuser is the
// reject flag; m_tdata holds the clock after the step and the emitted byte.
// A result passes through the command queue and then the output register.
// Throughput: one command per cycle for merge and advance while m_tready
// is high; an emit holds the back end for one output register load per byte.
// Commands sit in a QUEUE_DEPTH entry queue; s_tready drops only when it
// is full, so a stalled receiver backs up into the queue first.
// Reset clears the clock to 00:00:00:00 at 24 fps and empties the queue.
module mtc_quarter_frame_timekeeper #(
  parameter int QUEUE_DEPTH = mtcqf_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mtcqf_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] data_byte, [8] backwards
  input  logic [1:0]                      s_tuser,  // [1:0] mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] frame_count, [10:5] second_count, [16:11] minute_count,
  // [21:17] hour_count, [23:22] rate_code, [30:24] out_byte
  output logic [mtcqf_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  output logic [0:0]                      m_tuser   // [0] status
);
  import mtcqf_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  mtcqf_front u_front (
    .mode      (s_tuser),
    .data_byte (s_tdata[7:0]),
    .backwards (s_tdata[8]),
    .cmd       (front_cmd)
  );

  assign s_tready = !queue_full;

  mtcqf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s_tvalid && !queue_full),
    .wr_data (front_cmd),
    .full    (queue_full),
    .rd_en   (queue_pop),
    .rd_data (queue_cmd),
    .empty   (queue_empty)
  );

  mtcqf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_valid (!queue_empty),
    .cmd_pop   (queue_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/mtcqf_checker.sv =====
// Port-level checks for the time code block, bound to the top level.
// Depends on mtcqf_pkg and mtc_quarter_frame_timekeeper.
module mtcqf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mtcqf_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast,
  input logic [0:0]                      m_tuser
);
  import mtcqf_pkg::*;

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // Only emit beats are non-final, and they are never rejected
  a_beat_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tuser[0])
    else $error("non-final result flagged as rejected");

  // Rejected results carry no quarter-frame byte
  a_reject_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[30:24] == '0)
    else $error("rejected result carries a byte");

  // Clock fields stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= FRAME_MAX && m_tdata[10:5] <= SEC_MAX
      && m_tdata[16:11] <= MIN_MAX && m_tdata[21:17] <= HOUR_MAX)
    else $error("clock field out of range");

endmodule

bind mtc_quarter_frame_timekeeper mtcqf_checker u_mtcqf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
